[hdl/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  // fit policy codes, the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  // one result item handed from the scan control to the output register
  typedef struct packed {
    logic        granted;
    logic [3:0]  granted_block;
    logic [15:0] remaining;
  } res_t;

endpackage

[hdl/fpba_mem.sv]
// ----------------------------------------------------------------------------
// fpba_mem
// Free size store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpba_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/fpba_ctrl.sv]
// ----------------------------------------------------------------------------
// fpba_ctrl
// Takes load and request items, scans the free size store one entry per
// cycle under the fit policy and writes the chosen entry back.
// ----------------------------------------------------------------------------
module fpba_ctrl #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    cfg_fit_policy,
  input  logic [4:0]                    cfg_block_count,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_mode,
  input  logic [3:0]                    in_block_index,
  input  logic [15:0]                   in_size,
  input  logic                          out_free,
  output logic                          res_load,
  output fpba_pkg::res_t                res,
  output logic                          mem_wr_en,
  output logic [$clog2(NUM_BLOCKS)-1:0] mem_wr_addr,
  output logic [SIZE_WIDTH-1:0]         mem_wr_data,
  output logic                          mem_rd_en,
  output logic [$clog2(NUM_BLOCKS)-1:0] mem_rd_addr,
  input  logic [SIZE_WIDTH-1:0]         mem_rd_data
);

  import fpba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         last_idx_r, last_idx_nxt;
  logic [AW-1:0]         chosen_r, chosen_nxt;
  logic [SIZE_WIDTH-1:0] best_r, best_nxt;
  logic [SIZE_WIDTH-1:0] size_r, size_nxt;
  logic                  found_r, found_nxt;

  logic                  accept;
  logic                  load_ok;
  logic                  first_fit;
  logic                  fits;
  logic                  take;
  logic                  scan_last;
  logic [SIZE_WIDTH-1:0] left;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_ok   = (32'(in_block_index) < NUM_BLOCKS);
  assign first_fit = (cfg_fit_policy != POL_BEST) && (cfg_fit_policy != POL_WORST);

  // candidate test on the entry whose data arrives this cycle
  assign fits = (mem_rd_data >= size_r);
  assign take = fits && (!found_r
                || ((cfg_fit_policy == POL_BEST)  && (mem_rd_data < best_r))
                || ((cfg_fit_policy == POL_WORST) && (mem_rd_data > best_r)));
  assign scan_last = (idx_r == last_idx_r) || (first_fit && fits);

  assign left = best_r - size_r;

  // loads write in idle, the chosen entry is written back on completion
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(in_block_index);
    mem_wr_data = SIZE_WIDTH'(in_size);
    if (state_r == ST_DONE) begin
      mem_wr_en   = out_free && found_r;
      mem_wr_addr = chosen_r;
      mem_wr_data = left;
    end else if (accept && (in_mode == MODE_LOAD) && load_ok) begin
      mem_wr_en = 1'b1;
    end
  end

  assign mem_rd_en   = (accept && (in_mode == MODE_REQ))
                       || ((state_r == ST_SCAN) && !scan_last);
  assign mem_rd_addr = (state_r == ST_SCAN) ? AW'(idx_r + 1'b1) : '0;

  assign res_load          = (state_r == ST_DONE) && out_free;
  assign res.granted       = found_r;
  assign res.granted_block = found_r ? 4'(chosen_r) : 4'd0;
  assign res.remaining     = found_r ? 16'(left) : 16'd0;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    chosen_nxt   = chosen_r;
    best_nxt     = best_r;
    size_nxt     = size_r;
    found_nxt    = found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_REQ)) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          size_nxt  = SIZE_WIDTH'(in_size);
          // block count saturates at the store depth
          if (32'(cfg_block_count) > NUM_BLOCKS) begin
            last_idx_nxt = AW'(NUM_BLOCKS - 1);
          end else begin
            last_idx_nxt = AW'(cfg_block_count - 5'd1);
          end
          state_nxt = (cfg_block_count == 5'd0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          found_nxt  = 1'b1;
          chosen_nxt = idx_r;
          best_nxt   = mem_rd_data;
        end
        if (scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    chosen_r   <= chosen_nxt;
    best_r     <= best_nxt;
    size_r     <= size_nxt;
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("store written and read in the same cycle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= last_idx_r))
    else $error("scan index past the last searched block");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && found_r) |-> (chosen_r <= last_idx_r))
    else $error("granted block outside the searched range");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> in_tready)
    else $error("no return to idle after a result item");

endmodule

[hdl/fit_policy_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block allocator with first, best and worst fit over a free size store.
//
//   channel  direction  tdata (low bit up)               tuser
//   in_      slave      block_index[3:0], size[19:4]     mode
//   out_     master     granted_block[3:0], remaining    granted
//   cfg_     write      index 0 fit_policy, 1 block_count
//
// A request scans block_count entries (saturated at NUM_BLOCKS) and stops
// early under first fit when a block fits: one stored entry is compared per
// cycle through the single read port. Reset is synchronous; the store is not
// cleared, blocks must be loaded before they are searched. A stalled result
// waits in the output register while the next item is taken; a second result
// stalls the scan at its end.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // block_index, size
  input  logic                              in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // granted_block, remaining
  output logic                              out_tuser   // granted
);

  import fpba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);

  logic [1:0]            fit_policy_r;
  logic [4:0]            block_count_r;
  logic                  out_valid_r;
  res_t                  out_res_r;
  logic                  out_free;
  logic                  res_load;
  res_t                  res;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [SIZE_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [SIZE_WIDTH-1:0] mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r  <= POL_FIRST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:  fit_policy_r  <= cfg_wdata[1:0];
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  fpba_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_fit_policy  (fit_policy_r),
    .cfg_block_count (block_count_r),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_mode         (in_tuser),
    .in_block_index  (in_tdata[3:0]),
    .in_size         (in_tdata[19:4]),
    .out_free        (out_free),
    .res_load        (res_load),
    .res             (res),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

  // output register parts the result side from the scan
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.granted;
  assign out_tdata  = {4'd0, out_res_r.remaining, out_res_r.granted_block};

endmodule
